/* rtl/core/hte_pkg.sv */
// shared types and constants for the table-driven prefix-code encoder
`timescale 1ns / 1ps

package hte_pkg;

  localparam int unsigned SYM_W       = 8;
  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned IN_LEN_W    = 6;
  localparam int unsigned IN_CODE_W   = 32;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned PAD_W       = 3;
  localparam int unsigned OP_Q_DEPTH  = 2;
  localparam int unsigned RES_Q_DEPTH = 2;

  // command codes on the input channel
  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_ENCODE = 2'd1,
    CMD_FLUSH  = 2'd2
  } cmd_e;

  // classified operation handed from front to back
  typedef enum logic [1:0] {
    OP_ENCODE = 2'd0,
    OP_ERROR  = 2'd1,
    OP_FLUSH  = 2'd2
  } op_kind_e;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic [PAD_W-1:0]  pad_bits;
    logic              error;
    logic              last;
  } res_t;

endpackage

/* rtl/core/hte_ram.sv */
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module hte_ram #(
  parameter int unsigned WIDTH = 38,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/hte_fifo.sv */
// small synchronous queue with push/full and pop/empty sides
`timescale 1ns / 1ps

module hte_fifo #(
  parameter int unsigned WIDTH = 14,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

/* rtl/core/hte_front.sv */
// front end: table loads, table lookup and classification of operations
`timescale 1ns / 1ps

module hte_front
  import hte_pkg::*;
#(
  parameter int unsigned LEN_W  = 6,
  parameter int unsigned CODE_W = 32,
  parameter int unsigned LIM    = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  output logic                 full_o,
  input  logic [1:0]           cmd_i,
  input  logic [SYM_W-1:0]     symbol_i,
  input  logic [IN_LEN_W-1:0]  code_len_i,
  input  logic [IN_CODE_W-1:0] code_bits_i,
  output logic                 op_valid_o,
  input  logic                 op_ready_i,
  output op_kind_e             op_kind_o,
  output logic [LEN_W-1:0]     op_len_o,
  output logic [CODE_W-1:0]    op_code_o
);

  logic                    accept;
  logic                    is_load, is_encode, is_flush;
  logic [LEN_W-1:0]        len_sat;
  logic [TABLE_DEPTH-1:0]  vld_q;
  logic                    s1_valid_q, s1_valid_d;
  logic                    s1_flush_q;
  logic                    s1_vld_q;
  logic [LEN_W+CODE_W-1:0] rd_data;
  logic [LEN_W-1:0]        rd_len;

  assign full_o    = s1_valid_q && !op_ready_i;
  assign accept    = push_i && !full_o;
  assign is_load   = (cmd_i == CMD_LOAD);
  assign is_encode = (cmd_i == CMD_ENCODE);
  assign is_flush  = (cmd_i == CMD_FLUSH);

  // lengths above the limit saturate
  assign len_sat = (code_len_i > IN_LEN_W'(LIM)) ? LEN_W'(LIM) : LEN_W'(code_len_i);

  hte_ram #(
    .WIDTH (LEN_W + CODE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (accept && is_load),
    .waddr_i (symbol_i),
    .wdata_i ({len_sat, code_bits_i[CODE_W-1:0]}),
    .re_i    (accept && is_encode),
    .raddr_i (symbol_i),
    .rdata_o (rd_data)
  );

  assign rd_len = rd_data[LEN_W+CODE_W-1:CODE_W];

  always_comb begin
    s1_valid_d = s1_valid_q && !op_ready_i;
    if (accept && (is_encode || is_flush)) begin
      s1_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      s1_valid_q <= 1'b0;
      s1_flush_q <= 1'b0;
      s1_vld_q   <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (accept && is_load) begin
        vld_q[symbol_i] <= 1'b1;
      end
      if (accept && (is_encode || is_flush)) begin
        s1_flush_q <= is_flush;
        s1_vld_q   <= vld_q[symbol_i];
      end
    end
  end

  assign op_valid_o = s1_valid_q;
  assign op_len_o   = rd_len;
  assign op_code_o  = rd_data[CODE_W-1:0];

  always_comb begin
    if (s1_flush_q) begin
      op_kind_o = OP_FLUSH;
    end else if (!s1_vld_q || (rd_len == '0)) begin
      op_kind_o = OP_ERROR;
    end else begin
      op_kind_o = OP_ENCODE;
    end
  end

endmodule

/* rtl/core/hte_back.sv */
// back end: msb-first bit packer that emits one byte per cycle while the result side is ready
`timescale 1ns / 1ps

module hte_back
  import hte_pkg::*;
#(
  parameter int unsigned LEN_W  = 6,
  parameter int unsigned CODE_W = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              op_valid_i,
  output logic              op_ready_o,
  input  op_kind_e          op_kind_i,
  input  logic [LEN_W-1:0]  op_len_i,
  input  logic [CODE_W-1:0] op_code_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output res_t              res_o
);

  localparam int unsigned BUF_W = CODE_W + BYTE_W;
  localparam int unsigned REM_W = $clog2(CODE_W + BYTE_W);

  logic [BYTE_W-1:0] pend_byte_q, pend_byte_d;
  logic [2:0]        pend_cnt_q, pend_cnt_d;
  logic              busy_q, busy_d;
  logic [BUF_W-1:0]  buf_q, buf_d;
  logic [REM_W-1:0]  rem_q, rem_d;

  logic [LEN_W-1:0]  shamt;
  logic [CODE_W-1:0] code_left;
  logic [BUF_W-1:0]  cat;
  logic [REM_W-1:0]  total;
  logic [REM_W-1:0]  rem_next;
  logic              take;

  // code left-aligned right behind the pending bits
  assign shamt     = LEN_W'(CODE_W) - op_len_i;
  assign code_left = op_code_i << shamt;
  assign cat       = {pend_byte_q, {CODE_W{1'b0}}} | ({code_left, {BYTE_W{1'b0}}} >> pend_cnt_q);
  assign total     = REM_W'(pend_cnt_q) + REM_W'(op_len_i);
  assign rem_next  = rem_q - REM_W'(BYTE_W);

  // encode needs no result slot when it is taken, error and flush do
  assign op_ready_o = !busy_q && ((op_kind_i == OP_ENCODE) || res_ready_i);
  assign take       = op_valid_i && op_ready_o;

  always_comb begin
    pend_byte_d = pend_byte_q;
    pend_cnt_d  = pend_cnt_q;
    busy_d      = busy_q;
    buf_d       = buf_q;
    rem_d       = rem_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (busy_q) begin
      if (res_ready_i) begin
        res_valid_o      = 1'b1;
        res_o.out_byte   = buf_q[BUF_W-1 -: BYTE_W];
        res_o.byte_valid = 1'b1;
        res_o.last       = (rem_next < REM_W'(BYTE_W));
        buf_d            = buf_q << BYTE_W;
        rem_d            = rem_next;
        if (rem_next < REM_W'(BYTE_W)) begin
          busy_d      = 1'b0;
          pend_byte_d = buf_q[BUF_W-BYTE_W-1 -: BYTE_W];
          pend_cnt_d  = rem_next[2:0];
        end
      end
    end else if (take) begin
      case (op_kind_i)
        OP_ENCODE: begin
          if (total >= REM_W'(BYTE_W)) begin
            busy_d = 1'b1;
            buf_d  = cat;
            rem_d  = total;
          end else begin
            pend_byte_d = cat[BUF_W-1 -: BYTE_W];
            pend_cnt_d  = total[2:0];
          end
        end
        OP_ERROR: begin
          res_valid_o = 1'b1;
          res_o.error = 1'b1;
          res_o.last  = 1'b1;
        end
        OP_FLUSH: begin
          res_valid_o = 1'b1;
          res_o.last  = 1'b1;
          if (pend_cnt_q != '0) begin
            res_o.out_byte   = pend_byte_q;
            res_o.byte_valid = 1'b1;
            res_o.pad_bits   = PAD_W'(4'd8 - {1'b0, pend_cnt_q});
          end
          pend_byte_d = '0;
          pend_cnt_d  = '0;
        end
        default: begin
          res_valid_o = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_byte_q <= '0;
      pend_cnt_q  <= '0;
      busy_q      <= 1'b0;
    end else begin
      pend_byte_q <= pend_byte_d;
      pend_cnt_q  <= pend_cnt_d;
      busy_q      <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
    rem_q <= rem_d;
  end

  // pending bits below the fill level stay zero
  a_pend_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_byte_q & (8'hFF >> pend_cnt_q)) == 8'h00)
    else $error("pending byte holds bits beyond its count");

  // a byte run only goes on while a whole byte is left
  a_busy_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (rem_q >= REM_W'(BYTE_W)))
    else $error("packer busy with less than one byte left");

  // a result without a byte carries no byte and no padding
  a_empty_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.byte_valid) |-> (res_o.out_byte == '0 && res_o.pad_bits == '0))
    else $error("result without byte carries data");

  // the final byte of a run returns the packer to idle
  a_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && res_valid_o && res_o.last) |=> !busy_q)
    else $error("packer stays busy after last byte");

endmodule

/* rtl/core/huffman_table_encoder_bit_packer.sv */
// top level of the table-driven prefix-code encoder with msb-first bit packer
//
// usage
//   input queue side: push/full; a transaction carries cmd_i (load, encode, flush),
//   symbol_i, code_len_i and code_bits_i. loads write the 256-entry code table.
//   result queue side: empty/pop; the oldest result sits on the result ports while
//   empty is low and leaves on a cycle with pop high.
// path through the block
//   flush or unknown symbol: front lookup register, operation queue, packer, result queue
//   encode: as above, with completed bytes held in the packer buffer before the result queue
// flow
//   the front takes one transaction per cycle while full is low; loads finish in the front
//   the packer answers a flush or error as it takes it; an encode that completes n bytes
//   (0 to 4) keeps it busy while it emits them, and it takes no new operation meanwhile
// reset
//   clears the table valid bits (every symbol absent), the pending byte and count
//   and both internal queues; the table ram itself is not swept
// stalls
//   when pop stays low the result queue fills, the packer holds, the operation
//   queue fills and full rises; nothing is dropped
`timescale 1ns / 1ps

module huffman_table_encoder_bit_packer
  import hte_pkg::*;
#(
  parameter int unsigned MAX_CODE_LEN = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input queue side
  input  logic                 push,
  output logic                 full,
  input  logic [1:0]           cmd_i,
  input  logic [SYM_W-1:0]     symbol_i,
  input  logic [IN_LEN_W-1:0]  code_len_i,
  input  logic [IN_CODE_W-1:0] code_bits_i,
  // result queue side
  output logic                 empty,
  input  logic                 pop,
  output logic [BYTE_W-1:0]    out_byte_o,
  output logic                 byte_valid_o,
  output logic [PAD_W-1:0]     pad_bits_o,
  output logic                 error_o,
  output logic                 last_o
);

  // effective code length limit and the table field widths that follow from it
  localparam int unsigned LIM    = (MAX_CODE_LEN < IN_CODE_W) ? MAX_CODE_LEN : IN_CODE_W;
  localparam int unsigned LEN_W  = $clog2(LIM + 1);
  localparam int unsigned CODE_W = LIM;
  localparam int unsigned OP_W   = 2 + LEN_W + CODE_W;
  localparam int unsigned RES_W  = $bits(res_t);

  // front to operation queue
  logic              f_op_valid;
  logic              opq_full;
  op_kind_e          f_op_kind;
  logic [LEN_W-1:0]  f_op_len;
  logic [CODE_W-1:0] f_op_code;

  // operation queue to back
  logic              opq_empty;
  logic [OP_W-1:0]   opq_rdata;
  logic              b_op_ready;

  // back to result queue
  logic              b_res_valid;
  res_t              b_res;
  logic              resq_full;
  logic [RES_W-1:0]  resq_rdata;
  res_t              res_head;

  hte_front #(
    .LEN_W  (LEN_W),
    .CODE_W (CODE_W),
    .LIM    (LIM)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .cmd_i       (cmd_i),
    .symbol_i    (symbol_i),
    .code_len_i  (code_len_i),
    .code_bits_i (code_bits_i),
    .op_valid_o  (f_op_valid),
    .op_ready_i  (!opq_full),
    .op_kind_o   (f_op_kind),
    .op_len_o    (f_op_len),
    .op_code_o   (f_op_code)
  );

  // short queue that decouples lookup from packing
  hte_fifo #(
    .WIDTH (OP_W),
    .DEPTH (OP_Q_DEPTH)
  ) u_op_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_op_valid),
    .full_o  (opq_full),
    .wdata_i ({f_op_kind, f_op_len, f_op_code}),
    .pop_i   (b_op_ready),
    .empty_o (opq_empty),
    .rdata_o (opq_rdata)
  );

  hte_back #(
    .LEN_W  (LEN_W),
    .CODE_W (CODE_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (!opq_empty),
    .op_ready_o  (b_op_ready),
    .op_kind_i   (op_kind_e'(opq_rdata[OP_W-1 -: 2])),
    .op_len_i    (opq_rdata[CODE_W +: LEN_W]),
    .op_code_i   (opq_rdata[CODE_W-1:0]),
    .res_valid_o (b_res_valid),
    .res_ready_i (!resq_full),
    .res_o       (b_res)
  );

  // result queue, so the packer keeps going while the receiver stalls
  hte_fifo #(
    .WIDTH (RES_W),
    .DEPTH (RES_Q_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (b_res_valid),
    .full_o  (resq_full),
    .wdata_i (b_res),
    .pop_i   (pop),
    .empty_o (empty),
    .rdata_o (resq_rdata)
  );

  assign res_head     = res_t'(resq_rdata);
  assign out_byte_o   = res_head.out_byte;
  assign byte_valid_o = res_head.byte_valid;
  assign pad_bits_o   = res_head.pad_bits;
  assign error_o      = res_head.error;
  assign last_o       = res_head.last;

endmodule
